>>> design/bmpneg_pkg.sv
// shared types and constants for the bmp negative stream block
`default_nettype none
package bmpneg_pkg;

  // header layout, byte offsets from the start of the file
  localparam int HDR_POS_W     = 6;
  localparam int HEADER_BYTES  = 54;
  localparam logic [HDR_POS_W-1:0] HDR_LEN   = HDR_POS_W'(HEADER_BYTES);
  localparam logic [HDR_POS_W-1:0] HDR_LAST  = HDR_POS_W'(HEADER_BYTES - 1);
  localparam logic [HDR_POS_W-1:0] POS_MAGIC0 = HDR_POS_W'(0);
  localparam logic [HDR_POS_W-1:0] POS_MAGIC1 = HDR_POS_W'(1);
  localparam logic [HDR_POS_W-1:0] POS_WIDTH  = HDR_POS_W'(18);
  localparam logic [HDR_POS_W-1:0] POS_HEIGHT = HDR_POS_W'(22);
  localparam logic [HDR_POS_W-1:0] POS_DEPTH  = HDR_POS_W'(28);
  localparam logic [HDR_POS_W-1:0] POS_COMPR  = HDR_POS_W'(30);

  // field values
  localparam logic [7:0]  MAGIC_B    = 8'd66;
  localparam logic [7:0]  MAGIC_M    = 8'd77;
  localparam logic [15:0] DEPTH_24   = 16'd24;
  localparam logic [7:0]  PIXEL_MAX  = 8'd255;

  typedef enum logic [2:0] {
    ST_PENDING    = 3'd0,
    ST_OK         = 3'd1,
    ST_NOT_BMP    = 3'd2,
    ST_COMPRESSED = 3'd3,
    ST_NOT_24BPP  = 3'd4,
    ST_SIZE       = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] data_in;
    logic       last_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       last_out;
    status_t    status;
  } out_word_t;

endpackage
`default_nettype wire

>>> design/bmpneg_parse.sv
// header capture, pixel tracking and per-byte result for the bmp negative stream
`default_nettype none
module bmpneg_parse #(
  parameter int DIM_BITS = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  take,
  input  bmpneg_pkg::in_word_t word,
  output bmpneg_pkg::out_word_t result
);
  import bmpneg_pkg::*;

  localparam int CNT_W = DIM_BITS + 2;

  logic [HDR_POS_W-1:0] hdr_pos, hdr_pos_next;
  logic [DIM_BITS-1:0]  img_width, img_width_next;
  logic [DIM_BITS-1:0]  img_height, img_height_next;
  logic [15:0]          bit_depth, bit_depth_next;
  logic                 compr_nz, compr_nz_next;
  logic                 too_large, too_large_next;
  logic                 magic_ok, magic_ok_next;
  status_t              status, status_next;
  logic [CNT_W-1:0]     row_cnt, row_cnt_next;
  logic [DIM_BITS-1:0]  rows_done, rows_done_next;
  logic [1:0]           row_pad, row_pad_next;

  logic [1:0]           w_byte, h_byte;
  logic [CNT_W-1:0]     pixel_bytes, row_len, row_cnt_inc;
  logic                 in_pixels;

  // merge one little-endian byte into a dimension
  function automatic logic [DIM_BITS-1:0] dim_merge(
    input logic [DIM_BITS-1:0] dim,
    input logic [1:0]          k,
    input logic [7:0]          b
  );
    logic [DIM_BITS-1:0] r;
    r = dim;
    for (int p = 0; p < DIM_BITS; p++) begin
      if ((p / 8) == int'(k)) begin
        r[p] = r[p] | b[p % 8];
      end
    end
    return r;
  endfunction

  // any set bit at or above the supported dimension width
  function automatic logic dim_over(input logic [1:0] k, input logic [7:0] b);
    logic f;
    f = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (b[i] && (8 * int'(k) + i) >= DIM_BITS) begin
        f = 1'b1;
      end
    end
    return f;
  endfunction

  // pixel geometry
  assign pixel_bytes = {1'b0, img_width, 1'b0} + {2'b00, img_width};
  assign row_len     = pixel_bytes + {{(CNT_W-2){1'b0}}, row_pad};
  assign row_cnt_inc = row_cnt + 1'b1;
  assign in_pixels   = (status == ST_OK) && (img_width != '0) &&
                       (rows_done < img_height);
  assign w_byte      = 2'(hdr_pos - POS_WIDTH);
  assign h_byte      = 2'(hdr_pos - POS_HEIGHT);

  // next state and result byte
  always_comb begin
    hdr_pos_next    = hdr_pos;
    img_width_next  = img_width;
    img_height_next = img_height;
    bit_depth_next  = bit_depth;
    compr_nz_next   = compr_nz;
    too_large_next  = too_large;
    magic_ok_next   = magic_ok;
    status_next     = status;
    row_cnt_next    = row_cnt;
    rows_done_next  = rows_done;
    row_pad_next    = row_pad;
    result.data_out = word.data_in;
    result.last_out = word.last_in;

    if (hdr_pos < HDR_LEN) begin
      hdr_pos_next = hdr_pos + 1'b1;
      if (hdr_pos == POS_MAGIC0) begin
        magic_ok_next = (word.data_in == MAGIC_B);
      end else if (hdr_pos == POS_MAGIC1) begin
        magic_ok_next = magic_ok && (word.data_in == MAGIC_M);
      end else if (hdr_pos >= POS_WIDTH && hdr_pos < POS_WIDTH + 3'd4) begin
        img_width_next = dim_merge(img_width, w_byte, word.data_in);
        too_large_next = too_large | dim_over(w_byte, word.data_in);
      end else if (hdr_pos >= POS_HEIGHT && hdr_pos < POS_HEIGHT + 3'd4) begin
        img_height_next = dim_merge(img_height, h_byte, word.data_in);
        too_large_next  = too_large | dim_over(h_byte, word.data_in);
      end else if (hdr_pos == POS_DEPTH) begin
        bit_depth_next = {8'h00, word.data_in};
      end else if (hdr_pos == POS_DEPTH + 1'b1) begin
        bit_depth_next = {word.data_in, bit_depth[7:0]};
      end else if (hdr_pos >= POS_COMPR && hdr_pos < POS_COMPR + 3'd4) begin
        compr_nz_next = compr_nz | (word.data_in != 8'h00);
      end

      // header complete: decide status
      if (hdr_pos == HDR_LAST) begin
        if (!magic_ok) begin
          status_next = ST_NOT_BMP;
        end else if (compr_nz) begin
          status_next = ST_COMPRESSED;
        end else if (bit_depth != DEPTH_24) begin
          status_next = ST_NOT_24BPP;
        end else if (too_large) begin
          status_next = ST_SIZE;
        end else begin
          status_next = ST_OK;
        end
        row_pad_next   = img_width[1:0];
        row_cnt_next   = '0;
        rows_done_next = '0;
      end
    end else if (in_pixels) begin
      if (row_cnt < pixel_bytes) begin
        result.data_out = PIXEL_MAX - word.data_in;
      end
      if (row_cnt_inc >= row_len) begin
        row_cnt_next   = '0;
        rows_done_next = rows_done + 1'b1;
      end else begin
        row_cnt_next = row_cnt_inc;
      end
    end

    result.status = status_next;

    // end of file: restart the parse
    if (word.last_in) begin
      hdr_pos_next    = '0;
      img_width_next  = '0;
      img_height_next = '0;
      bit_depth_next  = '0;
      compr_nz_next   = 1'b0;
      too_large_next  = 1'b0;
      magic_ok_next   = 1'b0;
      status_next     = ST_PENDING;
      row_cnt_next    = '0;
      rows_done_next  = '0;
      row_pad_next    = '0;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_pos    <= '0;
      img_width  <= '0;
      img_height <= '0;
      bit_depth  <= '0;
      compr_nz   <= 1'b0;
      too_large  <= 1'b0;
      magic_ok   <= 1'b0;
      status     <= ST_PENDING;
      row_cnt    <= '0;
      rows_done  <= '0;
      row_pad    <= '0;
    end else if (take) begin
      hdr_pos    <= hdr_pos_next;
      img_width  <= img_width_next;
      img_height <= img_height_next;
      bit_depth  <= bit_depth_next;
      compr_nz   <= compr_nz_next;
      too_large  <= too_large_next;
      magic_ok   <= magic_ok_next;
      status     <= status_next;
      row_cnt    <= row_cnt_next;
      rows_done  <= rows_done_next;
      row_pad    <= row_pad_next;
    end
  end

endmodule
`default_nettype wire

>>> design/bmp24_negative_stream_top.sv
// output: the result word of each accepted file word is registered in the output register
// throughput: one word per cycle; the input stalls only while the output register is full
// and the output side stalls, since parse state and result are decided in the cycle of accept
// reset: synchronous rst clears the parse state and empties the output register
// the parse also restarts by itself after every word marked last
`default_nettype none
module bmp24_negative_stream_top #(
  parameter int DIM_BITS = 16
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   file_valid,
  output logic                  file_stall,
  input  bmpneg_pkg::in_word_t  file_word,
  output logic                  neg_valid,
  input  wire                   neg_stall,
  output bmpneg_pkg::out_word_t neg_word
);
  import bmpneg_pkg::*;

  logic      take;
  out_word_t result;

  // input handshake
  assign file_stall = neg_valid && neg_stall;
  assign take       = file_valid && !file_stall;

  bmpneg_parse #(
    .DIM_BITS(DIM_BITS)
  ) u_parse (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .word   (file_word),
    .result (result)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      neg_valid <= 1'b0;
    end else if (take) begin
      neg_valid <= 1'b1;
    end else if (!neg_stall) begin
      neg_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (take) begin
      neg_word <= result;
    end
  end

endmodule
`default_nettype wire

>>> dv/tb_bmp24_negative_stream_top.sv
// testbench for the bmp negative stream block: generated bmp files checked word by word
module tb_bmp24_negative_stream_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bmpneg_pkg::*;

  localparam int DIM_W        = 16;
  localparam int RANDOM_BYTES = 300;
  localparam int HOLD_CYCLES  = 300;
  localparam int RUN_LIMIT    = 400000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      file_valid = 1'b0;
  logic      file_stall;
  in_word_t  file_word = '0;
  logic      neg_valid;
  logic      neg_stall = 1'b0;
  out_word_t neg_word;

  bmp24_negative_stream_top #(.DIM_BITS(DIM_W)) dut (
    .clk        (clk),
    .rst        (rst),
    .file_valid (file_valid),
    .file_stall (file_stall),
    .file_word  (file_word),
    .neg_valid  (neg_valid),
    .neg_stall  (neg_stall),
    .neg_word   (neg_word)
  );

  // clock, 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  in_word_t    file_words_pending[$];
  out_word_t   neg_words_due[$];
  int          bytes_total = 0;
  int          bytes_taken = 0;
  int          mismatch_count = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned cycle_count = 0;

  // predictor state for the header parse and pixel walk
  logic [5:0]  hdr_pos;
  logic [15:0] img_w;
  logic [15:0] img_h;
  logic [15:0] depth;
  logic        compr_nz;
  logic        too_big;
  logic        magic_ok;
  status_t     cur_status;
  logic [17:0] row_pos;
  logic [15:0] rows_seen;
  logic [1:0]  pad;

  function automatic void clear_parse();
    hdr_pos    = '0;
    img_w      = '0;
    img_h      = '0;
    depth      = '0;
    compr_nz   = 1'b0;
    too_big    = 1'b0;
    magic_ok   = 1'b0;
    cur_status = ST_PENDING;
    row_pos    = '0;
    rows_seen  = '0;
    pad        = '0;
  endfunction

  // byte k of a 32-bit dimension field sets bits beyond the supported size
  function automatic logic dim_overflows(int k, logic [7:0] b);
    int lowbit;
    lowbit = 8 * k;
    if (lowbit >= DIM_W) return b != 8'd0;
    if (DIM_W - lowbit < 8) return (b >> (DIM_W - lowbit)) != 8'd0;
    return 1'b0;
  endfunction

  // expected output word for one file word; advances the parse state
  function automatic out_word_t negative_of(in_word_t w);
    out_word_t   r;
    logic [7:0]  b;
    int          k;
    int unsigned pix_bytes;
    int unsigned row_len;
    b = w.data_in;
    r.data_out = b;
    if (hdr_pos < HDR_LEN) begin
      if (hdr_pos == POS_MAGIC0) begin
        magic_ok = (b == MAGIC_B);
      end else if (hdr_pos == POS_MAGIC1) begin
        magic_ok = magic_ok && (b == MAGIC_M);
      end else if (hdr_pos >= POS_WIDTH && hdr_pos <= POS_WIDTH + 6'd3) begin
        k = hdr_pos - POS_WIDTH;
        if (k < 2) img_w = img_w | (16'(b) << (8 * k));
        if (dim_overflows(k, b)) too_big = 1'b1;
      end else if (hdr_pos >= POS_HEIGHT && hdr_pos <= POS_HEIGHT + 6'd3) begin
        k = hdr_pos - POS_HEIGHT;
        if (k < 2) img_h = img_h | (16'(b) << (8 * k));
        if (dim_overflows(k, b)) too_big = 1'b1;
      end else if (hdr_pos == POS_DEPTH) begin
        depth = 16'(b);
      end else if (hdr_pos == POS_DEPTH + 6'd1) begin
        depth = depth | (16'(b) << 8);
      end else if (hdr_pos >= POS_COMPR && hdr_pos <= POS_COMPR + 6'd3) begin
        if (b != 8'd0) compr_nz = 1'b1;
      end
      // status is settled on the final header byte
      if (hdr_pos == HDR_LAST) begin
        if (!magic_ok) cur_status = ST_NOT_BMP;
        else if (compr_nz) cur_status = ST_COMPRESSED;
        else if (depth != DEPTH_24) cur_status = ST_NOT_24BPP;
        else if (too_big) cur_status = ST_SIZE;
        else cur_status = ST_OK;
        pad       = img_w[1:0];
        row_pos   = '0;
        rows_seen = '0;
      end
      hdr_pos = hdr_pos + 6'd1;
    end else if (cur_status == ST_OK && img_w != 16'd0 && rows_seen < img_h) begin
      pix_bytes = img_w * 3;
      row_len   = pix_bytes + pad;
      if (row_pos < pix_bytes) r.data_out = PIXEL_MAX - b;
      if (row_pos + 1 >= row_len) begin
        row_pos   = '0;
        rows_seen = rows_seen + 16'd1;
      end else begin
        row_pos = row_pos + 18'd1;
      end
    end
    r.last_out = w.last_in;
    r.status   = cur_status;
    if (w.last_in) clear_parse();
    return r;
  endfunction

  // build one bmp file and queue its bytes; cut truncates after that byte index
  task automatic queue_bmp(input logic [7:0] m0, input logic [7:0] m1,
                           input logic [31:0] w, input logic [31:0] h,
                           input logic [15:0] bpp, input logic [31:0] compr,
                           input int fill, input int tail, input int cut);
    logic [7:0] f[$];
    int         body;
    int         n;
    in_word_t   word;
    for (int i = 0; i < HEADER_BYTES; i++) f.push_back(8'($urandom));
    f[0] = m0;
    f[1] = m1;
    for (int i = 0; i < 4; i++) begin
      f[POS_WIDTH + i]  = w[8*i +: 8];
      f[POS_HEIGHT + i] = h[8*i +: 8];
      f[POS_COMPR + i]  = compr[8*i +: 8];
    end
    f[POS_DEPTH]     = bpp[7:0];
    f[POS_DEPTH + 1] = bpp[15:8];
    if (w[31:10] == 0 && h[31:6] == 0) body = h * (3 * w + w % 4);
    else body = $urandom_range(20);
    for (int i = 0; i < body; i++) f.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    for (int i = 0; i < tail; i++) f.push_back(8'($urandom));
    n = f.size();
    if (cut >= 0 && cut < n) n = cut + 1;
    for (int i = 0; i < n; i++) begin
      word.data_in = f[i];
      word.last_in = (i == n - 1);
      file_words_pending.push_back(word);
    end
  endtask

  // idle rates by phase of the run
  function automatic int tx_idle_pct();
    if (bytes_taken < bytes_total / 3) return 25;
    if (bytes_taken < 2 * bytes_total / 3) return 65;
    return 0;
  endfunction

  function automatic int rx_idle_pct();
    if (bytes_taken < bytes_total / 3) return 65;
    if (bytes_taken < 2 * bytes_total / 3) return 25;
    return 0;
  endfunction

  // driver: predict each accepted word, then offer the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      file_valid <= 1'b0;
    end else if (!file_valid || !file_stall) begin
      if (file_valid) begin
        neg_words_due.push_back(negative_of(file_word));
        bytes_taken <= bytes_taken + 1;
      end
      if (file_words_pending.size() != 0 &&
          (hold_left != 0 || $urandom_range(99) >= tx_idle_pct())) begin
        file_word  <= file_words_pending.pop_front();
        file_valid <= 1'b1;
      end else begin
        file_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off early in the run
  always @(posedge clk) begin
    if (rst) begin
      neg_stall <= 1'b0;
    end else if (hold_left != 0) begin
      neg_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && bytes_taken >= bytes_total / 6) begin
      neg_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      neg_stall <= ($urandom_range(99) < rx_idle_pct());
    end
  end

  // monitor: compare each result word with the oldest one due
  always @(posedge clk) begin
    out_word_t due;
    if (!rst && neg_valid && !neg_stall) begin
      if (neg_words_due.size() == 0) begin
        $display("%0t: unexpected word data=%h last=%b status=%0d", $time,
                 neg_word.data_out, neg_word.last_out, neg_word.status);
        mismatch_count++;
      end else begin
        due = neg_words_due.pop_front();
        if (neg_word !== due) begin
          $display("%0t: expected data=%h last=%b status=%0d, got data=%h last=%b status=%0d",
                   $time, due.data_out, due.last_out, due.status,
                   neg_word.data_out, neg_word.last_out, neg_word.status);
          mismatch_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int          start;
    int          pick;
    logic [7:0]  m0;
    logic [7:0]  m1;
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] compr;
    logic [15:0] bpp;
    clear_parse();

    // good images, every padding amount, pixel extremes, trailing bytes
    queue_bmp(MAGIC_B, MAGIC_M, 1, 2, DEPTH_24, 0, -1, 0, -1);
    queue_bmp(MAGIC_B, MAGIC_M, 2, 2, DEPTH_24, 0, 0, 3, -1);
    queue_bmp(MAGIC_B, MAGIC_M, 3, 1, DEPTH_24, 0, 255, 0, -1);
    queue_bmp(MAGIC_B, MAGIC_M, 4, 2, DEPTH_24, 0, -1, 2, -1);
    queue_bmp(MAGIC_B, MAGIC_M, 257, 1, DEPTH_24, 0, -1, 1, -1);
    // header errors and their precedence
    queue_bmp(MAGIC_B, 8'd78, 2, 1, 16'd8, 32'h1, -1, 0, -1);
    queue_bmp(8'd0, MAGIC_M, 2, 1, DEPTH_24, 0, -1, 0, -1);
    queue_bmp(MAGIC_B, MAGIC_M, 2, 1, 16'd8, 32'h0100_0000, -1, 0, -1);
    queue_bmp(MAGIC_B, MAGIC_M, 2, 1, 16'd8, 0, -1, 0, -1);
    queue_bmp(MAGIC_B, MAGIC_M, 32'h0001_0002, 1, 16'h0118, 0, -1, 0, -1);
    queue_bmp(MAGIC_B, MAGIC_M, 32'h0001_0002, 1, DEPTH_24, 0, -1, 0, -1);
    queue_bmp(MAGIC_B, MAGIC_M, 2, 32'hFFFF_FFFE, DEPTH_24, 0, -1, 0, -1);
    queue_bmp(MAGIC_B, MAGIC_M, 32'h8000_0000, 1, DEPTH_24, 0, -1, 0, -1);
    // empty pixel arrays
    queue_bmp(MAGIC_B, MAGIC_M, 0, 3, DEPTH_24, 0, -1, 5, -1);
    queue_bmp(MAGIC_B, MAGIC_M, 2, 0, DEPTH_24, 0, -1, 4, -1);
    // short files
    queue_bmp(MAGIC_B, MAGIC_M, 1, 1, DEPTH_24, 0, -1, 0, 0);
    queue_bmp(MAGIC_B, MAGIC_M, 1, 1, DEPTH_24, 0, -1, 0, 10);
    queue_bmp(MAGIC_B, MAGIC_M, 1, 1, DEPTH_24, 0, -1, 0, HEADER_BYTES - 1);
    queue_bmp(MAGIC_B, MAGIC_M, 3, 2, DEPTH_24, 0, 0, 0, HEADER_BYTES + 7);

    // random files, mostly well formed
    start = file_words_pending.size();
    while (file_words_pending.size() - start < RANDOM_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        queue_bmp(MAGIC_B, MAGIC_M, $urandom_range(7), $urandom_range(4), DEPTH_24, 0, -1,
                  ($urandom_range(2) == 0) ? $urandom_range(1, 6) : 0,
                  ($urandom_range(7) == 0) ? $urandom_range(54, 150) : -1);
      end else if (pick < 85) begin
        m0 = ($urandom_range(3) == 0) ? 8'($urandom) : MAGIC_B;
        m1 = ($urandom_range(3) == 0) ? 8'($urandom) : MAGIC_M;
        bpp = ($urandom_range(2) == 0) ? 16'($urandom) : DEPTH_24;
        compr = '0;
        if ($urandom_range(2) == 0) compr[8*$urandom_range(3) +: 8] = 8'($urandom_range(1, 255));
        w = $urandom_range(6);
        if ($urandom_range(2) == 0) w[8*$urandom_range(2, 3) +: 8] = 8'($urandom_range(1, 255));
        h = $urandom_range(3);
        if ($urandom_range(3) == 0) h = ~32'($urandom_range(3));
        queue_bmp(m0, m1, w, h, bpp, compr, -1, $urandom_range(3), -1);
      end else if (pick < 95) begin
        queue_bmp(MAGIC_B, MAGIC_M, $urandom_range(5), $urandom_range(3), DEPTH_24, 0, -1, 0,
                  $urandom_range(HEADER_BYTES - 1));
      end else begin
        queue_bmp(8'($urandom), 8'($urandom), $urandom, $urandom, 16'($urandom), $urandom,
                  -1, 0, $urandom_range(40));
      end
    end
    bytes_total = file_words_pending.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken != bytes_total || neg_words_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
